[hdl/u8sd_pkg.sv]
// Package for the UTF-8 stream decoder: field widths, the result record and
// the lead-byte and codepoint assembly functions. No dependencies.
package u8sd_pkg;

	localparam int TEXT_W   = 8;
	localparam int CP_W     = 21;
	localparam int OUT_DW   = 24;
	localparam int OUT_UW   = 2;
	localparam int CNT_W    = 2;
	localparam int LEN_W    = 3;

	typedef struct packed {
		logic [CP_W-1:0] codepoint;
		logic            invalid;
		logic            last_of_run;
		logic            text_done;
	} result_t;

	// Sequence length announced by a lead byte; zero for a follower or 0xF8 and up.
	function automatic logic [LEN_W-1:0] lead_length(input logic [TEXT_W-1:0] b);
		logic [LEN_W-1:0] len;
		if (!b[7]) begin
			len = 3'd1;
		end else if (b[7:5] == 3'b110) begin
			len = 3'd2;
		end else if (b[7:4] == 4'b1110) begin
			len = 3'd3;
		end else if (b[7:3] == 5'b11110) begin
			len = 3'd4;
		end else begin
			len = 3'd0;
		end
		return len;
	endfunction

	// Assembles a codepoint from up to four bytes, lead byte in the low byte.
	// Followers contribute their low six bits without any check.
	function automatic logic [CP_W-1:0] combine(input logic [31:0] w,
			input logic [LEN_W-1:0] len);
		logic [CP_W-1:0] cp;
		case (len)
			3'd1:    cp = {13'd0, w[7:0]};
			3'd2:    cp = {10'd0, w[4:0], w[13:8]};
			3'd3:    cp = {5'd0, w[3:0], w[13:8], w[21:16]};
			default: cp = {w[2:0], w[13:8], w[21:16], w[29:24]};
		endcase
		return cp;
	endfunction

endpackage

[hdl/utf8_stream_decoder.sv]
// Lenient UTF-8 stream decoder: one text byte per transfer in, one codepoint
// per transfer out. Depends on u8sd_pkg.
//
// Each result is decoded from the input register into the single output register.
// Throughput: one byte per cycle while the output is not stalled; an end-of-text
// byte holds the input register until its results (one to three) have all been emitted.
// Reset: arst_n clears the valid flags, the held byte count and the flush position;
// held bytes need no reset, so the decoder is ready as soon as reset is released.
module utf8_stream_decoder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [u8sd_pkg::TEXT_W-1:0] s_tdata,  // [7:0] text_byte
	input  logic                        s_tlast,  // end_of_text
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [u8sd_pkg::OUT_DW-1:0] m_tdata,  // [20:0] codepoint, [23:21] zero
	output logic [u8sd_pkg::OUT_UW-1:0] m_tuser,  // [0] invalid, [1] last_of_run
	output logic                        m_tlast   // text_done
);

	logic                         vld_s1;
	logic [u8sd_pkg::TEXT_W-1:0]  byte_s1;
	logic                         eot_s1;

	logic [u8sd_pkg::TEXT_W-1:0]  held_q [3];
	logic [u8sd_pkg::CNT_W-1:0]   count_q;
	logic [u8sd_pkg::CNT_W-1:0]   pos_q;

	logic                         out_vld_q;
	u8sd_pkg::result_t            out_q;

	logic [3:0][7:0]              buf_w;
	logic [31:0]                  win_w;
	logic [u8sd_pkg::LEN_W-1:0]   len_w;
	logic [u8sd_pkg::LEN_W-1:0]   avail_w;
	logic [3:0]                   adv_w;
	logic                         fits_w;
	logic                         hold_w;
	logic                         final_w;
	logic                         out_free_w;
	logic                         emit_w;
	logic                         s1_done_w;
	u8sd_pkg::result_t            res_w;

	// Held bytes followed by the new byte form the text still to be decoded.
	always_comb begin
		buf_w = '0;
		case (count_q)
			2'd0: begin
				buf_w[0] = byte_s1;
			end
			2'd1: begin
				buf_w[0] = held_q[0];
				buf_w[1] = byte_s1;
			end
			2'd2: begin
				buf_w[0] = held_q[0];
				buf_w[1] = held_q[1];
				buf_w[2] = byte_s1;
			end
			default: begin
				buf_w[0] = held_q[0];
				buf_w[1] = held_q[1];
				buf_w[2] = held_q[2];
				buf_w[3] = byte_s1;
			end
		endcase
	end

	assign avail_w = {1'b0, count_q} + 3'd1;
	assign win_w   = 32'(buf_w) >> {pos_q, 3'b000};
	assign len_w   = u8sd_pkg::lead_length(win_w[7:0]);
	assign fits_w  = (len_w != 3'd0)
		&& (({2'b00, pos_q} + {1'b0, len_w}) <= {1'b0, avail_w});
	assign adv_w   = fits_w ? ({2'b00, pos_q} + {1'b0, len_w}) : ({2'b00, pos_q} + 4'd1);
	assign final_w = adv_w >= {1'b0, avail_w};

	// Outside end of text, a sequence longer than the bytes on hand is held.
	assign hold_w     = !eot_s1 && (len_w > avail_w);
	assign out_free_w = !out_vld_q || m_tready;
	assign emit_w     = vld_s1 && !hold_w && out_free_w;
	assign s1_done_w  = vld_s1 && (hold_w || (out_free_w && final_w));
	assign s_tready   = !vld_s1 || s1_done_w;

	always_comb begin
		res_w.codepoint   = fits_w ? u8sd_pkg::combine(win_w, len_w) : '0;
		res_w.invalid     = !fits_w;
		res_w.last_of_run = final_w;
		res_w.text_done   = final_w && eot_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			vld_s1 <= 1'b1;
		end else if (s1_done_w) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			eot_s1  <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pos_q   <= '0;
		end else if (vld_s1 && hold_w) begin
			count_q <= count_q + 2'd1;
		end else if (emit_w) begin
			if (final_w) begin
				count_q <= '0;
				pos_q   <= '0;
			end else begin
				pos_q <= adv_w[u8sd_pkg::CNT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && hold_w) begin
			held_q[count_q] <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit_w) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_w) begin
			out_q <= res_w;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {3'b000, out_q.codepoint};
	assign m_tuser  = {out_q.last_of_run, out_q.invalid};
	assign m_tlast  = out_q.text_done;

endmodule

[hdl/u8sd_checker.sv]
// Port-level checks for utf8_stream_decoder and the bind that attaches them.
// Depends on u8sd_pkg.
module u8sd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [u8sd_pkg::OUT_DW-1:0] m_tdata,
	input logic [u8sd_pkg::OUT_UW-1:0] m_tuser,
	input logic                        m_tlast
);

	// A stalled result keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output result changed while stalled");

	// Error results carry a zero codepoint.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == '0)
		else $error("invalid result with nonzero codepoint");

	// The end of the text is always the end of a byte's results.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser[1])
		else $error("text_done without last_of_run");

	// Codepoints never exceed 21 bits.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[u8sd_pkg::OUT_DW-1:u8sd_pkg::CP_W] == '0)
		else $error("codepoint padding bits set");

endmodule

bind utf8_stream_decoder u8sd_checker u_u8sd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for utf8_stream_decoder: directed and random byte streams
// against a built-in decoder model, with random sender gaps and receiver stalls.
// Depends on u8sd_pkg and the utf8_stream_decoder RTL.
module tb_top;

	localparam int BYTE_TARGET = 360;
	localparam int STUCK_LIMIT = 1000;

	typedef enum {RDY_ALWAYS, RDY_RANDOM, RDY_STALLS} ready_mode_t;

	// Tracks the open UTF-8 sequence and queues the codepoints it should produce.
	class cp_scoreboard_t;
		u8sd_pkg::result_t pending_cps[$];
		bit [7:0] held[3];
		bit [1:0] held_cnt;
		bit [2:0] need_len;
		int       errors;
		int       checked;
		int       bytes_seen;
		int       texts_seen;
		int       invalid_seen;

		function bit [2:0] seq_len(bit [7:0] b);
			if (b[7] == 1'b0) return 3'd1;
			if (b[7:5] == 3'b110) return 3'd2;
			if (b[7:4] == 4'b1110) return 3'd3;
			if (b[7:3] == 5'b11110) return 3'd4;
			return 3'd0;
		endfunction

		function bit [20:0] join_bytes(bit [7:0] b0, bit [7:0] b1, bit [7:0] b2,
				bit [7:0] b3, int n);
			case (n)
				1: return {13'd0, b0};
				2: return {10'd0, b0[4:0], b1[5:0]};
				3: return {5'd0, b0[3:0], b1[5:0], b2[5:0]};
				default: return {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
			endcase
		endfunction

		function u8sd_pkg::result_t make_result(bit [20:0] cp, bit bad);
			u8sd_pkg::result_t r;
			r.codepoint   = bad ? 21'd0 : cp;
			r.invalid     = bad;
			r.last_of_run = 1'b0;
			r.text_done   = 1'b0;
			return r;
		endfunction

		function void take_byte(bit [7:0] b, bit eot);
			u8sd_pkg::result_t res[3];
			bit [7:0] seq[7];
			int       m;
			int       pos;
			int       n;
			int       len;
			int       i;
			n = 0;
			bytes_seen++;
			for (i = 0; i < 7; i++) seq[i] = 8'd0;
			if (eot) begin
				// Held bytes plus this one are decoded as a finished text.
				m = 0;
				if (need_len != 3'd0) begin
					for (i = 0; i < held_cnt; i++) begin
						seq[m] = held[i];
						m++;
					end
				end
				seq[m] = b;
				m++;
				pos = 0;
				while (pos < m && n < 3) begin
					len = seq_len(seq[pos]);
					if (len != 0 && pos + len <= m) begin
						res[n] = make_result(join_bytes(seq[pos], seq[pos+1], seq[pos+2],
							seq[pos+3], len), 1'b0);
						pos += len;
					end else begin
						res[n] = make_result(21'd0, 1'b1);
						pos++;
					end
					n++;
				end
				res[n-1].text_done = 1'b1;
				held_cnt = 2'd0;
				need_len = 3'd0;
				texts_seen++;
			end else if (need_len == 3'd0) begin
				len = seq_len(b);
				if (len == 1) begin
					res[0] = make_result({13'd0, b}, 1'b0);
					n = 1;
				end else if (len == 0) begin
					res[0] = make_result(21'd0, 1'b1);
					n = 1;
				end else begin
					held[0]  = b;
					held_cnt = 2'd1;
					need_len = len[2:0];
				end
			end else if (held_cnt + 1 >= need_len || held_cnt >= 2'd3) begin
				len = (need_len > 3'd4) ? 4 : need_len;
				seq[0] = held[0];
				seq[1] = held[1];
				seq[2] = held[2];
				seq[len-1] = b;
				res[0] = make_result(join_bytes(seq[0], seq[1], seq[2], seq[3], len), 1'b0);
				n = 1;
				held_cnt = 2'd0;
				need_len = 3'd0;
			end else begin
				held[held_cnt] = b;
				held_cnt++;
			end
			if (n > 0) res[n-1].last_of_run = 1'b1;
			for (i = 0; i < n; i++) begin
				if (res[i].invalid) invalid_seen++;
				pending_cps = {pending_cps, res[i]};
			end
		endfunction

		function void check_result(bit [u8sd_pkg::OUT_DW-1:0] data,
				bit [u8sd_pkg::OUT_UW-1:0] user, bit last);
			u8sd_pkg::result_t want;
			if (pending_cps.size() == 0) begin
				$error("unexpected result: codepoint %h invalid %0b",
					data[u8sd_pkg::CP_W-1:0], user[0]);
				errors++;
				return;
			end
			want = pending_cps.pop_front();
			checked++;
			if (data[u8sd_pkg::CP_W-1:0] != want.codepoint) begin
				$error("codepoint: expected %h, got %h", want.codepoint,
					data[u8sd_pkg::CP_W-1:0]);
				errors++;
			end
			if (data[u8sd_pkg::OUT_DW-1:u8sd_pkg::CP_W] != '0) begin
				$error("tdata padding: expected 0, got %h",
					data[u8sd_pkg::OUT_DW-1:u8sd_pkg::CP_W]);
				errors++;
			end
			if (user[0] != want.invalid) begin
				$error("invalid: expected %0b, got %0b", want.invalid, user[0]);
				errors++;
			end
			if (user[1] != want.last_of_run) begin
				$error("last_of_run: expected %0b, got %0b", want.last_of_run, user[1]);
				errors++;
			end
			if (last != want.text_done) begin
				$error("text_done: expected %0b, got %0b", want.text_done, last);
				errors++;
			end
		endfunction
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        s_tvalid;
	logic                        s_tready;
	logic [u8sd_pkg::TEXT_W-1:0] s_tdata;
	logic                        s_tlast;
	logic                        m_tvalid;
	logic                        m_tready;
	logic [u8sd_pkg::OUT_DW-1:0] m_tdata;
	logic [u8sd_pkg::OUT_UW-1:0] m_tuser;
	logic                        m_tlast;

	cp_scoreboard_t sb;
	int           bytes_sent;
	int           burst_left;
	int           stuck_cycles;
	ready_mode_t  ready_mode;
	int           mode_left;
	int           stall_left;

	utf8_stream_decoder uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// Both sides are observed here at the same edge so prediction always precedes checking.
	always @(posedge clk) begin
		if (s_tvalid && s_tready) sb.take_byte(s_tdata, s_tlast);
		if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stuck_cycles = 0;
		else stuck_cycles++;
	end

	initial begin
		wait (stuck_cycles >= STUCK_LIMIT);
		$display("no transfer for %0d cycles", STUCK_LIMIT);
		$display("utf8_stream_decoder verification failed");
		$finish;
	end

	// The receiver switches between always ready, random ready and stall streaks.
	always @(negedge clk) begin
		if (mode_left == 0) begin
			ready_mode = ready_mode_t'($urandom_range(0, 2));
			mode_left  = $urandom_range(20, 80);
		end
		mode_left--;
		case (ready_mode)
			RDY_ALWAYS: m_tready <= 1'b1;
			RDY_RANDOM: m_tready <= ($urandom_range(0, 2) != 0);
			default: begin
				if (stall_left > 0) begin
					m_tready <= 1'b0;
					stall_left--;
				end else begin
					m_tready <= 1'b1;
					if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 12);
				end
			end
		endcase
	end

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_byte(input bit [7:0] b, input bit eot);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
				: $urandom_range(1, 8);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= eot;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		burst_left--;
		bytes_sent++;
	endtask

	// A text of well-formed characters with random content, sometimes with a
	// corrupted follower or a last sequence cut short before the end flag.
	task automatic send_text();
		bit [7:0] txt[$];
		int       n_cp;
		int       len;
		int       i;
		int       k;
		int       cut;
		n_cp = $urandom_range(1, 8);
		len  = 1;
		for (i = 0; i < n_cp; i++) begin
			len = $urandom_range(1, 4);
			case (len)
				1: txt = {txt, 8'($urandom_range(0, 127))};
				2: txt = {txt, {3'b110, 5'($urandom)}};
				3: txt = {txt, {4'b1110, 4'($urandom)}};
				default: txt = {txt, {5'b11110, 3'($urandom)}};
			endcase
			for (k = 1; k < len; k++) begin
				if ($urandom_range(0, 7) == 0) txt = {txt, 8'($urandom)};
				else txt = {txt, {2'b10, 6'($urandom)}};
			end
		end
		if (len > 1 && $urandom_range(0, 3) == 0) begin
			cut = $urandom_range(1, len - 1);
			repeat (cut) void'(txt.pop_back());
		end
		for (i = 0; i < txt.size(); i++) send_byte(txt[i], i == txt.size() - 1);
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(0, 5) == 0);
	endtask

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tlast      = 1'b0;
		m_tready     = 1'b0;
		bytes_sent   = 0;
		burst_left   = 0;
		stuck_cycles = 0;
		mode_left    = 0;
		stall_left   = 0;
		ready_mode   = RDY_ALWAYS;
		sb = new();
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Extremes, every sequence length, stray followers, bad leads, overlong and
		// surrogate forms, then texts ending inside an open sequence.
		send_byte(8'h00, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'hC2, 1'b0); send_byte(8'hA9, 1'b0);
		send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b0); send_byte(8'hAC, 1'b0);
		send_byte(8'hF7, 1'b0); send_byte(8'hBF, 1'b0);
		send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hF8, 1'b0);
		send_byte(8'hC0, 1'b0); send_byte(8'h80, 1'b0);
		send_byte(8'hED, 1'b0); send_byte(8'hA0, 1'b0); send_byte(8'h80, 1'b0);
		send_byte(8'hF0, 1'b0); send_byte(8'h41, 1'b0); send_byte(8'h42, 1'b1);
		send_byte(8'hF0, 1'b0); send_byte(8'hF0, 1'b0);
		send_byte(8'hF0, 1'b0); send_byte(8'hF0, 1'b1);
		send_byte(8'hC2, 1'b1);
		send_byte(8'h41, 1'b1);

		while (bytes_sent < BYTE_TARGET) begin
			if ($urandom_range(0, 9) < 7) send_text();
			else send_noise();
		end
		s_tvalid <= 1'b0;

		while (sb.pending_cps.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Decoded %0d bytes in %0d texts; %0d results checked, %0d of them invalid.",
			sb.bytes_seen, sb.texts_seen, sb.checked, sb.invalid_seen);
		if (sb.errors == 0 && sb.pending_cps.size() == 0) begin
			$display("utf8_stream_decoder verification clean");
		end else begin
			$display("utf8_stream_decoder verification failed");
		end
		$finish;
	end

endmodule
